// ===== rtl/core/gnuc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gnuc_pkg;

  // Grid geometry and counter width.
  localparam int unsigned Rows       = 24;
  localparam int unsigned Columns    = 32;
  localparam int unsigned CountWidth = 16;

  localparam int unsigned GridNodes = Rows * Columns;
  localparam int unsigned Win       = 2 * Rows;
  localparam int unsigned NodeW     = $clog2(GridNodes);
  localparam int unsigned WinW      = $clog2(Win);
  localparam int unsigned RowW      = $clog2(Rows);
  localparam int unsigned ColW      = $clog2(Columns);

  // Fixed field widths.
  localparam int unsigned SampleW = 16;
  localparam int unsigned RatioW  = 32;
  localparam int unsigned LimitW  = 32;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned TotalW  = 16;
  localparam int unsigned MagW    = 17;
  localparam int unsigned ProdW   = 2 * MagW;
  localparam int unsigned CmpW    = (NodeW > IdxW) ? NodeW : IdxW;
  localparam int unsigned DivCntW = $clog2(RatioW);

  localparam logic [MagW-1:0] Scale = MagW'(100000);

  // Stream packing.
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutFieldW = IdxW + RatioW + 1 + TotalW + 1;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;
  localparam int unsigned OutPadW   = OutDataW - OutFieldW;

  // Job queue between front and back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Neighbor slots inside a job.
  localparam int unsigned NbUp    = 0;
  localparam int unsigned NbDown  = 1;
  localparam int unsigned NbLeft  = 2;
  localparam int unsigned NbRight = 3;

  // Register map and reset values.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NORMAL_LIMIT   = 3'd0,
    REG_SPECIAL_LIMIT  = 3'd1,
    REG_SPECIAL_MODE   = 3'd2,
    REG_SPECIAL_NODE_A = 3'd3,
    REG_SPECIAL_NODE_B = 3'd4,
    REG_SPECIAL_NODE_C = 3'd5,
    REG_SPECIAL_NODE_D = 3'd6
  } reg_idx_e;

  localparam logic [LimitW-1:0] NormalLimitRst  = LimitW'(22000);
  localparam logic [LimitW-1:0] SpecialLimitRst = LimitW'(26000);
  localparam logic              SpecialModeRst  = 1'b1;
  localparam logic [IdxW-1:0]   SpecialNodeARst = IdxW'(360);
  localparam logic [IdxW-1:0]   SpecialNodeBRst = IdxW'(383);
  localparam logic [IdxW-1:0]   SpecialNodeCRst = IdxW'(384);
  localparam logic [IdxW-1:0]   SpecialNodeDRst = IdxW'(407);

  typedef struct packed {
    logic [LimitW-1:0]          normal_limit;
    logic [LimitW-1:0]          special_limit;
    logic                       special_mode;
    logic [3:0][IdxW-1:0]       special_node;
  } cfg_t;

  typedef struct packed {
    logic [NodeW-1:0]           node;
    logic [SampleW-1:0]         self_v;
    logic [3:0][SampleW-1:0]    nb;
    logic [3:0]                 nb_valid;
    logic                       last;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/gnuc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gnuc_front import gnuc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] in_sample_i,
  input  logic               hold_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output job_t               job_o
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_PUSH
  } fstate_e;

  localparam logic [2:0] ReadSteps = 3'd4;

  fstate_e            state_q;
  logic [NodeW-1:0]   pos_q;
  logic [RowW-1:0]    prow_q;
  logic [ColW-1:0]    pcol_q;
  logic [WinW-1:0]    wptr_q;
  logic [SampleW-1:0] sample_q;
  logic               final_q;
  logic               in_flush_q;
  logic [2:0]         step_q;
  logic [WinW-1:0]    ns_q;
  logic [RowW-1:0]    jrow_q;
  job_t               job_q;

  logic [SampleW-1:0] win_mem [Win];
  logic [SampleW-1:0] rd_data_q;

  logic               accept;
  logic               push;
  logic               win_we;
  logic [SampleW-1:0] win_wdata;
  logic               win_re;
  logic [WinW-1:0]    win_raddr;

  function automatic logic [WinW-1:0] slot_inc(logic [WinW-1:0] s);
    return (s == WinW'(Win - 1)) ? '0 : s + WinW'(1);
  endfunction

  function automatic logic [WinW-1:0] slot_dec(logic [WinW-1:0] s);
    return (s == '0) ? WinW'(Win - 1) : s - WinW'(1);
  endfunction

  // Adding Rows modulo 2*Rows also steps back by Rows.
  function automatic logic [WinW-1:0] slot_add_rows(logic [WinW-1:0] s);
    logic [WinW:0] t;
    t = {1'b0, s} + (WinW + 1)'(Rows);
    if (t >= (WinW + 1)'(Win)) t = t - (WinW + 1)'(Win);
    return t[WinW-1:0];
  endfunction

  assign in_ready_o  = (state_q == F_IDLE) && !hold_i;
  assign accept      = in_valid_i && in_ready_o;
  assign push        = (state_q == F_PUSH) && job_ready_i;
  assign job_valid_o = (state_q == F_PUSH);
  assign job_o       = job_q;

  // The sample is stored only after the pending node has read its old slot.
  assign win_we    = (accept && (pcol_q == '0)) || (push && !in_flush_q);
  assign win_wdata = accept ? in_sample_i : sample_q;
  assign win_re    = (state_q == F_READ) && (step_q < ReadSteps);

  always_comb begin
    case (step_q)
      3'd0:    win_raddr = ns_q;
      3'd1:    win_raddr = slot_dec(ns_q);
      3'd2:    win_raddr = slot_inc(ns_q);
      default: win_raddr = slot_add_rows(ns_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (win_we) win_mem[wptr_q] <= win_wdata;
    if (win_re) rd_data_q <= win_mem[win_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      pos_q      <= '0;
      prow_q     <= '0;
      pcol_q     <= '0;
      wptr_q     <= '0;
      sample_q   <= '0;
      final_q    <= 1'b0;
      in_flush_q <= 1'b0;
      step_q     <= '0;
      ns_q       <= '0;
      jrow_q     <= '0;
      job_q      <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            sample_q <= in_sample_i;
            if (pcol_q != '0) begin
              job_q.node              <= pos_q - NodeW'(Rows);
              job_q.nb_valid[NbUp]    <= (prow_q != '0);
              job_q.nb_valid[NbDown]  <= (prow_q != RowW'(Rows - 1));
              job_q.nb_valid[NbLeft]  <= (pcol_q != ColW'(1));
              job_q.nb_valid[NbRight] <= 1'b1;
              job_q.nb[NbRight]       <= in_sample_i;
              job_q.last              <= (pos_q != NodeW'(GridNodes - 1));
              final_q                 <= (pos_q == NodeW'(GridNodes - 1));
              in_flush_q              <= 1'b0;
              ns_q                    <= slot_add_rows(wptr_q);
              step_q                  <= '0;
              state_q                 <= F_READ;
            end else begin
              pos_q <= pos_q + NodeW'(1);
              if (prow_q == RowW'(Rows - 1)) begin
                prow_q <= '0;
                pcol_q <= pcol_q + ColW'(1);
              end else begin
                prow_q <= prow_q + RowW'(1);
              end
              wptr_q <= slot_inc(wptr_q);
            end
          end
        end
        F_READ: begin
          case (step_q)
            3'd1:    job_q.self_v      <= rd_data_q;
            3'd2:    job_q.nb[NbUp]    <= rd_data_q;
            3'd3:    job_q.nb[NbDown]  <= rd_data_q;
            3'd4:    job_q.nb[NbLeft]  <= rd_data_q;
            default: ;
          endcase
          if (step_q == ReadSteps) begin
            state_q <= F_PUSH;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        F_PUSH: begin
          if (push) begin
            step_q <= '0;
            if (!in_flush_q) begin
              if (final_q) begin
                // Frame end: position wraps, then the last column is flushed.
                pos_q                   <= '0;
                prow_q                  <= '0;
                pcol_q                  <= '0;
                wptr_q                  <= '0;
                in_flush_q              <= 1'b1;
                jrow_q                  <= '0;
                job_q.node              <= NodeW'(GridNodes - Rows);
                ns_q                    <= WinW'((GridNodes - Rows) % Win);
                job_q.nb_valid[NbUp]    <= 1'b0;
                job_q.nb_valid[NbDown]  <= 1'b1;
                job_q.nb_valid[NbLeft]  <= 1'b1;
                job_q.nb_valid[NbRight] <= 1'b0;
                job_q.last              <= 1'b0;
                state_q                 <= F_READ;
              end else begin
                pos_q <= pos_q + NodeW'(1);
                if (prow_q == RowW'(Rows - 1)) begin
                  prow_q <= '0;
                  pcol_q <= pcol_q + ColW'(1);
                end else begin
                  prow_q <= prow_q + RowW'(1);
                end
                wptr_q  <= slot_inc(wptr_q);
                state_q <= F_IDLE;
              end
            end else if (jrow_q == RowW'(Rows - 1)) begin
              in_flush_q <= 1'b0;
              state_q    <= F_IDLE;
            end else begin
              jrow_q                 <= jrow_q + RowW'(1);
              job_q.node             <= job_q.node + NodeW'(1);
              ns_q                   <= slot_inc(ns_q);
              job_q.nb_valid[NbUp]   <= 1'b1;
              job_q.nb_valid[NbDown] <= (jrow_q + RowW'(1) != RowW'(Rows - 1));
              job_q.last             <= (jrow_q + RowW'(1) == RowW'(Rows - 1));
              state_q                <= F_READ;
            end
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gnuc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gnuc_queue import gnuc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_data_o
);

  job_t             q_mem [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = (count_q < QCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = q_mem[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) q_mem[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gnuc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gnuc_back import gnuc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  job_t              job_i,
  input  cfg_t              cfg_i,
  output logic              clearing_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IdxW-1:0]   node_o,
  output logic              tested_o,
  output logic [RatioW-1:0] ratio_o,
  output logic              fail_o,
  output logic [TotalW-1:0] fail_total_o,
  output logic              any_fail_o,
  output logic              run_end_o
);

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_MAG,
    B_MUL,
    B_DIV,
    B_DONE
  } bstate_e;

  bstate_e              state_q;
  logic [NodeW-1:0]     clr_addr_q;
  job_t                 job_q;
  logic [MagW-1:0]      m_q;
  logic                 zero_q;
  logic                 special_q;
  logic [RatioW-1:0]    quot_q;
  logic [SampleW-1:0]   rem_q;
  logic [DivCntW-1:0]   div_cnt_q;
  logic                 sticky_q;

  logic                 out_valid_q;
  logic [IdxW-1:0]      node_q;
  logic                 tested_q;
  logic [RatioW-1:0]    ratio_q;
  logic                 fail_q;
  logic [TotalW-1:0]    fail_total_q;
  logic                 any_fail_q;
  logic                 run_end_q;

  logic [CountWidth-1:0] cnt_mem [GridNodes];
  logic [CountWidth-1:0] cnt_rd_q;

  logic                  pop;
  logic                  out_free;
  logic                  load_out;
  logic [MagW-1:0]       m_w;
  logic                  special_w;
  logic [ProdW-1:0]      prod_w;
  logic [SampleW:0]      rem_shift;
  logic                  rem_ge;
  logic [SampleW:0]      rem_next;
  logic [LimitW-1:0]     limit_w;
  logic                  fail_w;
  logic [CountWidth-1:0] cnt_inc;
  logic                  cnt_we;
  logic [NodeW-1:0]      cnt_waddr;
  logic [CountWidth-1:0] cnt_wdata;

  function automatic logic [MagW-1:0] diff_mag(logic [SampleW-1:0] nb, logic [SampleW-1:0] v);
    logic [SampleW-1:0] d;
    d = nb - v;
    return d[SampleW-1] ? (MagW'(1) << SampleW) - {1'b0, d} : {1'b0, d};
  endfunction

  assign job_ready_o = (state_q == B_IDLE);
  assign clearing_o  = (state_q == B_CLEAR);
  assign pop         = job_valid_i && job_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign load_out    = (state_q == B_DONE) && out_free;

  always_comb begin
    m_w = '0;
    for (int i = 0; i < 4; i++) begin
      if (job_q.nb_valid[i] && (diff_mag(job_q.nb[i], job_q.self_v) > m_w)) begin
        m_w = diff_mag(job_q.nb[i], job_q.self_v);
      end
    end
  end

  always_comb begin
    special_w = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (CmpW'(job_q.node) == CmpW'(cfg_i.special_node[i])) special_w = 1'b1;
    end
    special_w = special_w && cfg_i.special_mode;
  end

  assign prod_w = ProdW'(m_q) * ProdW'(Scale);

  // One quotient bit per cycle, restoring.
  assign rem_shift = {rem_q, quot_q[RatioW-1]};
  assign rem_ge    = (rem_shift >= {1'b0, job_q.self_v});
  assign rem_next  = rem_ge ? rem_shift - {1'b0, job_q.self_v} : rem_shift;

  assign limit_w = special_q ? cfg_i.special_limit : cfg_i.normal_limit;
  assign fail_w  = !zero_q && (quot_q > limit_w);
  assign cnt_inc = (fail_w && (cnt_rd_q != '1)) ? cnt_rd_q + CountWidth'(1) : cnt_rd_q;

  assign cnt_we    = (state_q == B_CLEAR) || (load_out && fail_w);
  assign cnt_waddr = (state_q == B_CLEAR) ? clr_addr_q : job_q.node;
  assign cnt_wdata = (state_q == B_CLEAR) ? '0 : cnt_inc;

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (pop) cnt_rd_q <= cnt_mem[job_i.node];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_CLEAR;
      clr_addr_q   <= '0;
      job_q        <= '0;
      m_q          <= '0;
      zero_q       <= 1'b0;
      special_q    <= 1'b0;
      quot_q       <= '0;
      rem_q        <= '0;
      div_cnt_q    <= '0;
      sticky_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      node_q       <= '0;
      tested_q     <= 1'b0;
      ratio_q      <= '0;
      fail_q       <= 1'b0;
      fail_total_q <= '0;
      any_fail_q   <= 1'b0;
      run_end_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !load_out) out_valid_q <= 1'b0;

      unique case (state_q)
        B_CLEAR: begin
          clr_addr_q <= clr_addr_q + NodeW'(1);
          if (clr_addr_q == NodeW'(GridNodes - 1)) state_q <= B_IDLE;
        end
        B_IDLE: begin
          if (pop) begin
            job_q   <= job_i;
            state_q <= B_MAG;
          end
        end
        B_MAG: begin
          m_q       <= m_w;
          zero_q    <= (job_q.self_v == '0);
          special_q <= special_w;
          state_q   <= B_MUL;
        end
        B_MUL: begin
          rem_q     <= '0;
          div_cnt_q <= '0;
          if (zero_q) begin
            quot_q  <= '0;
            state_q <= B_DONE;
          end else begin
            quot_q  <= prod_w[RatioW-1:0];
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          rem_q     <= rem_next[SampleW-1:0];
          quot_q    <= {quot_q[RatioW-2:0], rem_ge};
          div_cnt_q <= div_cnt_q + DivCntW'(1);
          if (div_cnt_q == DivCntW'(RatioW - 1)) state_q <= B_DONE;
        end
        B_DONE: begin
          if (load_out) begin
            out_valid_q  <= 1'b1;
            node_q       <= IdxW'(job_q.node);
            tested_q     <= !zero_q;
            ratio_q      <= quot_q;
            fail_q       <= fail_w;
            fail_total_q <= TotalW'(cnt_inc);
            any_fail_q   <= sticky_q || fail_w;
            run_end_q    <= job_q.last;
            sticky_q     <= sticky_q || fail_w;
            state_q      <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign node_o       = node_q;
  assign tested_o     = tested_q;
  assign ratio_o      = ratio_q;
  assign fail_o       = fail_q;
  assign fail_total_o = fail_total_q;
  assign any_fail_o   = any_fail_q;
  assign run_end_o    = run_end_q;

endmodule

`default_nettype wire

// ===== rtl/core/grid_neighbor_uniformity_check_top.sv =====
// A node result leaves after the item that completes its neighbors, passing the window reads
// in the front end and then the B_MAG, B_MUL, B_DIV and B_DONE states in the back end.
// The back end takes no new job until the radix-2 serial divider has finished the last one;
// a frame-final item yields ROWS + 1 results.
// Reset is asynchronous, active low; afterwards the per-node failure counters are cleared
// one entry per cycle, all ROWS * COLUMNS (768) of them, and no sample is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module grid_neighbor_uniformity_check_top import gnuc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // [15:0] sample
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [9:0] node, [41:10] ratio, [42] fail, [58:43] fail_total, [59] any_fail, rest zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tuser,  // [0] tested
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t              cfg_q;
  logic              clearing;
  logic              fq_valid;
  logic              fq_ready;
  job_t              fq_job;
  logic              qb_valid;
  logic              qb_ready;
  job_t              qb_job;
  logic [IdxW-1:0]   node;
  logic              tested;
  logic [RatioW-1:0] ratio;
  logic              fail;
  logic [TotalW-1:0] fail_total;
  logic              any_fail;
  logic              run_end;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal_limit    <= NormalLimitRst;
      cfg_q.special_limit   <= SpecialLimitRst;
      cfg_q.special_mode    <= SpecialModeRst;
      cfg_q.special_node[0] <= SpecialNodeARst;
      cfg_q.special_node[1] <= SpecialNodeBRst;
      cfg_q.special_node[2] <= SpecialNodeCRst;
      cfg_q.special_node[3] <= SpecialNodeDRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_NORMAL_LIMIT:   cfg_q.normal_limit    <= cfg_data_i[LimitW-1:0];
        REG_SPECIAL_LIMIT:  cfg_q.special_limit   <= cfg_data_i[LimitW-1:0];
        REG_SPECIAL_MODE:   cfg_q.special_mode    <= cfg_data_i[0];
        REG_SPECIAL_NODE_A: cfg_q.special_node[0] <= cfg_data_i[IdxW-1:0];
        REG_SPECIAL_NODE_B: cfg_q.special_node[1] <= cfg_data_i[IdxW-1:0];
        REG_SPECIAL_NODE_C: cfg_q.special_node[2] <= cfg_data_i[IdxW-1:0];
        REG_SPECIAL_NODE_D: cfg_q.special_node[3] <= cfg_data_i[IdxW-1:0];
        default: ;
      endcase
    end
  end

  gnuc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata[SampleW-1:0]),
    .hold_i      (clearing),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready),
    .job_o       (fq_job)
  );

  gnuc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_job)
  );

  gnuc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (qb_valid),
    .job_ready_o  (qb_ready),
    .job_i        (qb_job),
    .cfg_i        (cfg_q),
    .clearing_o   (clearing),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .node_o       (node),
    .tested_o     (tested),
    .ratio_o      (ratio),
    .fail_o       (fail),
    .fail_total_o (fail_total),
    .any_fail_o   (any_fail),
    .run_end_o    (run_end)
  );

  assign m_axis_tdata = {{OutPadW{1'b0}}, any_fail, fail_total, fail, ratio, node};
  assign m_axis_tuser = tested;
  assign m_axis_tlast = run_end;

  // No sample may enter while the failure counters are being cleared.
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready)
    else $error("sample accepted during counter clear");

  // An untested node carries neither a ratio nor a failure.
  a_untested_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !tested) |-> (ratio == '0) && !fail)
    else $error("untested node reports a ratio or failure");

  // A failing node must also raise the sticky flag and a nonzero count.
  a_fail_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && fail) |-> any_fail && (fail_total != '0 || CountWidth > TotalW))
    else $error("failure without sticky flag or count");

  // Once set, the sticky flag never drops on later results.
  a_sticky_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && any_fail) |=> !m_axis_tvalid || any_fail)
    else $error("sticky failure flag cleared");

endmodule

`default_nettype wire
